### design/abas_pkg.sv
// abas_pkg: shared types, sizes and codes of the announce airtime scheduler
// used by the top level and the divider; no dependencies
`timescale 1ns / 1ps
package abas_pkg;

  // sizes
  localparam int QUEUE_DEPTH    = 16;
  localparam int EMIT_LOG_DEPTH = 32;
  localparam int RESULT_LIMIT   = 16;
  localparam int QAW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW    = $clog2(QUEUE_DEPTH + 1);
  localparam int LAW    = (EMIT_LOG_DEPTH > 1) ? $clog2(EMIT_LOG_DEPTH) : 1;
  localparam int LCW    = $clog2(EMIT_LOG_DEPTH + 1);
  localparam int USED_W = 23 + LCW;
  localparam int NCW    = $clog2(RESULT_LIMIT + 1);
  localparam int DVD_W  = 23;
  localparam int DVS_W  = 24;
  localparam int CAP_W  = 41;
  localparam int DEM_W  = 44;
  localparam int CAP_DIVISOR   = 10000;
  localparam int MS_PER_BYTE8  = 8000;

  // function codes of an input item
  localparam logic FUNC_QUEUE = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_MAX_QUEUED = 2'd0,
    CFG_BITRATE    = 2'd1,
    CFG_CAP_PCT    = 2'd2,
    CFG_WINDOW     = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic        func;
    logic [15:0] packet_tag;
    logic [9:0]  length_bytes;
    logic [7:0]  hops;
    logic [47:0] now_ms;
  } abas_in_t;

  typedef struct packed {
    logic        accepted;
    logic        emitted;
    logic [15:0] out_tag;
    logic [7:0]  out_hops;
    logic [22:0] charge_ms;
    logic        last;
  } abas_out_t;

  typedef struct packed {
    logic [15:0] tag;
    logic [9:0]  len;
    logic [7:0]  hops;
  } queue_entry_t;

  typedef struct packed {
    logic [47:0] time_ms;
    logic [22:0] air;
  } log_entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ENQ,
    ST_CAP,
    ST_LOOP,
    ST_SCAN,
    ST_AIR,
    ST_PR_RD,
    ST_PR_CHK,
    ST_DECIDE,
    ST_PUSH,
    ST_COMPACT,
    ST_FINISH
  } state_t;

endpackage

### design/airtime_budget_announce_scheduler.sv
// airtime_budget_announce_scheduler: top level, control sequencer and datapath
// depends on abas_pkg, abas_ram and abas_div
`timescale 1ns / 1ps
// Usage
// An input item either queues an announce (func = queue) or runs a tick at
// now_ms. A queue item gives one result item with accepted set when stored.
// A tick sends queued announces, lowest hops first, while the windowed
// airtime stays within the cap, one result item per send, at most 16, and
// last marks the final one; a tick that sends nothing gives one empty item.
// Queue and emit log live in two rams with a registered read; the log
// is a ring, and a running sum of its airtime is kept in a register.
// A queue item's result is registered once the output is free, and the
// input is free again after it is handed over. A tick first forms the cap
// product, then per send scans the queue for the pick, divides for its
// airtime unless the bitrate is 0, prunes log records older than the window,
// decides and logs, and closes the gap in the queue; a last step ends the tick.
// One item is worked at a time: in_stall is high until all its results are
// handed to the output register. out_stall holds the output register and
// pauses the tick before its next send. Configuration is taken any cycle.
// Reset (synchronous, rst_n low) empties queue and log and loads defaults.
module airtime_budget_announce_scheduler (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  abas_pkg::abas_in_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output abas_pkg::abas_out_t out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [26:0]         cfg_data
);

  // configuration registers
  logic [4:0]  cfg_maxq_r;
  logic [23:0] cfg_rate_r;
  logic [13:0] cfg_pct_r;
  logic [26:0] cfg_win_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_maxq_r <= 5'd16;
      cfg_rate_r <= 24'd1200;
      cfg_pct_r  <= 14'd200;
      cfg_win_r  <= 27'd3600000;
    end else if (cfg_valid) begin
      unique case (abas_pkg::cfg_reg_e'(cfg_index))
        abas_pkg::CFG_MAX_QUEUED: cfg_maxq_r <= cfg_data[4:0];
        abas_pkg::CFG_BITRATE:    cfg_rate_r <= cfg_data[23:0];
        abas_pkg::CFG_CAP_PCT:    cfg_pct_r  <= cfg_data[13:0];
        abas_pkg::CFG_WINDOW:     cfg_win_r  <= cfg_data;
        default:                  cfg_maxq_r <= cfg_maxq_r;
      endcase
    end
  end

  abas_pkg::state_t state_r, state_nxt;

  // control state
  logic [abas_pkg::QCW-1:0]    q_cnt_r;
  logic [abas_pkg::LAW-1:0]    l_head_r;
  logic [abas_pkg::LCW-1:0]    l_cnt_r;
  logic [abas_pkg::USED_W-1:0] used_r;
  logic [abas_pkg::NCW-1:0]    n_r;
  logic                        pend_v_r;
  logic                        out_valid_r;
  logic                        rd_v_r;
  logic [abas_pkg::QCW-1:0]    idx_r;
  logic [abas_pkg::QCW-1:0]    idx_d_r;

  // payload registers
  abas_pkg::abas_out_t      out_r, pend_r;
  logic [47:0]              now_r, cutoff_r;
  logic [abas_pkg::CAP_W-1:0] cap_r;
  logic [abas_pkg::QCW-1:0] pick_r;
  abas_pkg::queue_entry_t   best_r;
  logic [22:0]              need_r;
  logic                     enq_ok_r;

  // memories
  logic                        q_we;
  logic [abas_pkg::QAW-1:0]    q_waddr, q_raddr;
  abas_pkg::queue_entry_t      q_wdata, q_rdata;
  logic                        l_we;
  logic [abas_pkg::LAW-1:0]    l_waddr;
  abas_pkg::log_entry_t        l_wdata, l_rdata;

  abas_ram #(.WIDTH($bits(abas_pkg::queue_entry_t)), .DEPTH(abas_pkg::QUEUE_DEPTH)) u_qram (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rdata)
  );

  abas_ram #(.WIDTH($bits(abas_pkg::log_entry_t)), .DEPTH(abas_pkg::EMIT_LOG_DEPTH)) u_lram (
    .clk(clk), .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
    .raddr(l_head_r), .rdata(l_rdata)
  );

  // serial divider for the packet airtime
  logic                       div_start;
  logic [abas_pkg::DVD_W-1:0] div_dvd;
  logic [abas_pkg::DVS_W-1:0] div_dvs;
  logic                       div_done;
  logic [abas_pkg::DVD_W-1:0] div_q;

  abas_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dvd),
    .divisor(div_dvs), .done(div_done), .quotient(div_q)
  );

  // derived conditions
  logic out_free;
  logic out_load;
  logic accept_in;
  logic q_room;
  logic scan_done, cmp_done;
  logic over_cap;
  logic log_full;
  logic [47:0] win48;
  logic [abas_pkg::LAW-1:0] l_tail;
  logic [abas_pkg::LAW-1:0] l_head_inc;
  logic [abas_pkg::DEM_W-1:0] demand;

  assign out_free  = !out_valid_r || !out_stall;
  assign accept_in = in_valid && !in_stall;
  assign q_room    = (32'(q_cnt_r) < 32'(cfg_maxq_r)) &&
                     (32'(q_cnt_r) < abas_pkg::QUEUE_DEPTH);
  assign scan_done = (idx_r == q_cnt_r) && !rd_v_r;
  assign cmp_done  = (idx_r >= q_cnt_r) && !rd_v_r;
  assign demand    = abas_pkg::DEM_W'(used_r) + abas_pkg::DEM_W'(need_r);
  // scaled demand against window*pct, same outcome as against the floored cap
  assign over_cap  = (demand * abas_pkg::DEM_W'(abas_pkg::CAP_DIVISOR)) >
                     abas_pkg::DEM_W'(cap_r);
  assign log_full  = 32'(l_cnt_r) >= abas_pkg::EMIT_LOG_DEPTH;
  assign win48     = 48'(cfg_win_r);
  assign l_head_inc = (32'(l_head_r) == abas_pkg::EMIT_LOG_DEPTH - 1) ?
                      '0 : abas_pkg::LAW'(l_head_r + 1'b1);
  assign l_tail    = ((32'(l_head_r) + 32'(l_cnt_r)) >= abas_pkg::EMIT_LOG_DEPTH) ?
                     abas_pkg::LAW'(32'(l_head_r) + 32'(l_cnt_r) - abas_pkg::EMIT_LOG_DEPTH) :
                     abas_pkg::LAW'(32'(l_head_r) + 32'(l_cnt_r));

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= abas_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and memory/divider controls
  always_comb begin
    state_nxt = state_r;
    in_stall  = 1'b1;
    out_load  = 1'b0;
    div_start = 1'b0;
    div_dvd   = abas_pkg::DVD_W'(best_r.len) *
                abas_pkg::DVD_W'(abas_pkg::MS_PER_BYTE8);
    div_dvs   = cfg_rate_r;
    q_we      = 1'b0;
    q_waddr   = q_cnt_r[abas_pkg::QAW-1:0];
    q_wdata   = '{tag: in_item.packet_tag, len: in_item.length_bytes, hops: in_item.hops};
    q_raddr   = idx_r[abas_pkg::QAW-1:0];
    l_we      = 1'b0;
    l_waddr   = l_tail;
    l_wdata   = '{time_ms: now_r, air: need_r};
    unique case (state_r)
      abas_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_item.func == abas_pkg::FUNC_TICK) begin
            state_nxt = abas_pkg::ST_CAP;
          end else begin
            q_we      = q_room;
            state_nxt = abas_pkg::ST_ENQ;
          end
        end
      end
      abas_pkg::ST_ENQ: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = abas_pkg::ST_IDLE;
        end
      end
      abas_pkg::ST_CAP: begin
        state_nxt = abas_pkg::ST_LOOP;
      end
      abas_pkg::ST_LOOP: begin
        if (q_cnt_r == '0 || 32'(n_r) >= abas_pkg::RESULT_LIMIT) begin
          state_nxt = abas_pkg::ST_FINISH;
        end else begin
          state_nxt = abas_pkg::ST_SCAN;
        end
      end
      abas_pkg::ST_SCAN: begin
        if (scan_done) begin
          if (cfg_rate_r == '0) begin
            state_nxt = abas_pkg::ST_PR_RD;
          end else begin
            div_start = 1'b1;
            state_nxt = abas_pkg::ST_AIR;
          end
        end
      end
      abas_pkg::ST_AIR: begin
        if (div_done) state_nxt = abas_pkg::ST_PR_RD;
      end
      abas_pkg::ST_PR_RD: begin
        state_nxt = (l_cnt_r == '0) ? abas_pkg::ST_DECIDE : abas_pkg::ST_PR_CHK;
      end
      abas_pkg::ST_PR_CHK: begin
        state_nxt = (l_rdata.time_ms < cutoff_r) ? abas_pkg::ST_PR_RD : abas_pkg::ST_DECIDE;
      end
      abas_pkg::ST_DECIDE: begin
        state_nxt = (log_full || over_cap) ? abas_pkg::ST_FINISH : abas_pkg::ST_PUSH;
      end
      abas_pkg::ST_PUSH: begin
        if (!pend_v_r || out_free) begin
          l_we      = 1'b1;
          out_load  = pend_v_r;
          state_nxt = abas_pkg::ST_COMPACT;
        end
      end
      abas_pkg::ST_COMPACT: begin
        q_we      = rd_v_r;
        q_waddr   = abas_pkg::QAW'(idx_d_r - 1'b1);
        q_wdata   = q_rdata;
        if (cmp_done) state_nxt = abas_pkg::ST_LOOP;
      end
      abas_pkg::ST_FINISH: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = abas_pkg::ST_IDLE;
        end
      end
      default: state_nxt = abas_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_cnt_r     <= '0;
      l_head_r    <= '0;
      l_cnt_r     <= '0;
      used_r      <= '0;
      n_r         <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      rd_v_r      <= 1'b0;
      idx_r       <= '0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        abas_pkg::ST_IDLE: begin
          n_r <= '0;
          if (accept_in && in_item.func == abas_pkg::FUNC_QUEUE && q_room) begin
            q_cnt_r <= abas_pkg::QCW'(q_cnt_r + 1'b1);
          end
        end
        abas_pkg::ST_LOOP: begin
          idx_r  <= '0;
          rd_v_r <= 1'b0;
        end
        abas_pkg::ST_SCAN: begin
          rd_v_r <= idx_r < q_cnt_r;
          if (idx_r < q_cnt_r) idx_r <= abas_pkg::QCW'(idx_r + 1'b1);
        end
        abas_pkg::ST_PR_CHK: begin
          if (l_rdata.time_ms < cutoff_r) begin
            l_head_r <= l_head_inc;
            l_cnt_r  <= abas_pkg::LCW'(l_cnt_r - 1'b1);
            used_r   <= abas_pkg::USED_W'(used_r - l_rdata.air);
          end
        end
        abas_pkg::ST_PUSH: begin
          if (!pend_v_r || out_free) begin
            pend_v_r <= 1'b1;
            l_cnt_r  <= abas_pkg::LCW'(l_cnt_r + 1'b1);
            used_r   <= abas_pkg::USED_W'(used_r + need_r);
            n_r      <= abas_pkg::NCW'(n_r + 1'b1);
            idx_r    <= abas_pkg::QCW'(pick_r + 1'b1);
            rd_v_r   <= 1'b0;
          end
        end
        abas_pkg::ST_COMPACT: begin
          rd_v_r <= idx_r < q_cnt_r;
          if (idx_r < q_cnt_r) idx_r <= abas_pkg::QCW'(idx_r + 1'b1);
          if (cmp_done) q_cnt_r <= abas_pkg::QCW'(q_cnt_r - 1'b1);
        end
        abas_pkg::ST_FINISH: begin
          if (out_free) begin
            pend_v_r <= 1'b0;
          end
        end
        default: begin
          rd_v_r <= rd_v_r;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    idx_d_r <= idx_r;
    unique case (state_r)
      abas_pkg::ST_IDLE: begin
        enq_ok_r <= q_room;
        now_r    <= in_item.now_ms;
        cutoff_r <= (in_item.now_ms > win48) ? in_item.now_ms - win48 : '0;
      end
      abas_pkg::ST_ENQ: begin
        if (out_free) begin
          out_r <= '{accepted: enq_ok_r, emitted: 1'b0, out_tag: '0, out_hops: '0,
                     charge_ms: '0, last: 1'b1};
        end
      end
      abas_pkg::ST_CAP: begin
        // window times share, still scaled by the divisor
        cap_r <= abas_pkg::CAP_W'(cfg_win_r) * abas_pkg::CAP_W'(cfg_pct_r);
      end
      abas_pkg::ST_SCAN: begin
        // minimum hops, earliest entry wins ties
        if (rd_v_r && (idx_d_r == '0 || q_rdata.hops < best_r.hops)) begin
          best_r <= q_rdata;
          pick_r <= idx_d_r;
        end
        if (scan_done) need_r <= '0;
      end
      abas_pkg::ST_AIR: begin
        if (div_done) need_r <= div_q[22:0];
      end
      abas_pkg::ST_PUSH: begin
        if (!pend_v_r || out_free) begin
          if (pend_v_r) out_r <= pend_r;
          pend_r <= '{accepted: 1'b0, emitted: 1'b1, out_tag: best_r.tag,
                      out_hops: best_r.hops, charge_ms: need_r, last: 1'b0};
        end
      end
      abas_pkg::ST_FINISH: begin
        if (out_free) begin
          if (pend_v_r) begin
            out_r <= '{accepted: pend_r.accepted, emitted: pend_r.emitted,
                       out_tag: pend_r.out_tag, out_hops: pend_r.out_hops,
                       charge_ms: pend_r.charge_ms, last: 1'b1};
          end else begin
            out_r <= '{accepted: 1'b0, emitted: 1'b0, out_tag: '0, out_hops: '0,
                       charge_ms: '0, last: 1'b1};
          end
        end
      end
      default: begin
        enq_ok_r <= enq_ok_r;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

### design/abas_ram.sv
// abas_ram: generic simple dual port ram, one write and one registered read
// no dependencies
`timescale 1ns / 1ps
module abas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/abas_div.sv
// abas_div: restoring serial divider, one quotient bit per cycle
// depends on abas_pkg for widths
`timescale 1ns / 1ps
module abas_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [abas_pkg::DVD_W-1:0] dividend,
  input  logic [abas_pkg::DVS_W-1:0] divisor,
  output logic                       done,
  output logic [abas_pkg::DVD_W-1:0] quotient
);

  localparam int CW = $clog2(abas_pkg::DVD_W + 1);

  logic [abas_pkg::DVD_W-1:0] dvd_r, dvd_nxt;
  logic [abas_pkg::DVS_W-1:0] rem_r, rem_nxt;
  logic [abas_pkg::DVS_W-1:0] dvs_r;
  logic [CW-1:0]              cnt_r, cnt_nxt;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [abas_pkg::DVS_W:0]   trial;

  // one restoring step
  always_comb begin
    trial    = {rem_r, dvd_r[abas_pkg::DVD_W-1]};
    dvd_nxt  = {dvd_r[abas_pkg::DVD_W-2:0], 1'b0};
    rem_nxt  = trial[abas_pkg::DVS_W-1:0];
    if (trial >= {1'b0, dvs_r}) begin
      rem_nxt    = abas_pkg::DVS_W'(trial - {1'b0, dvs_r});
      dvd_nxt[0] = 1'b1;
    end
    cnt_nxt  = cnt_r - CW'(1);
    busy_nxt = busy_r && (cnt_r != CW'(1));
    done_nxt = busy_r && (cnt_r == CW'(1));
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CW'(abas_pkg::DVD_W);
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      if (busy_r) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done     = done_r;
  assign quotient = dvd_r;

endmodule
